// ===== rtl/mrp_pkg.sv =====
// Shared types and constants for the motor position reply parser.
// No dependencies; imported by every module of the block except the checker.
`default_nettype none

package mrp_pkg;

	// Frame bytes and codes
	localparam logic [7:0]  CODE_POSITION = 8'h36;
	localparam logic [7:0]  TAIL_BYTE     = 8'h6B;

	// Configuration register indexes and reset values
	localparam logic        REG_DEVICE_ADDRESS = 1'b0;
	localparam logic        REG_POSITION_LIMIT = 1'b1;
	localparam logic [7:0]  DEV_ADDR_RST       = 8'h01;
	localparam logic [16:0] POS_LIMIT_RST      = 17'h10000;
	localparam int          CFG_DATA_W         = 17;

	// Scaling: tenths = count * 3600 / 65536, full turn saturates at 3600
	localparam logic [12:0] TENTHS_FULL = 13'd3600;
	// Degrees: (|t| + 5) / 10 via multiply by ceil(65536 / 10), shift by 16
	localparam logic [11:0] ROUND_HALF  = 12'd5;
	localparam logic [12:0] RECIP_TEN   = 13'd6554;

	// Completed-frame event from the byte parser
	typedef struct packed {
		logic        hit;
		logic        neg;
		logic [16:0] count;
	} frame_evt_t;

	// Stage-one payload: one beat worth of result before degree rounding
	typedef struct packed {
		logic        updated;
		logic        have;
		logic [12:0] tenths;
	} angle_s1_t;

endpackage

`default_nettype wire

// ===== rtl/mrp_frame.sv =====
// Byte-level reply frame parser: stage tracking, sign and count capture.
// Depends on mrp_pkg for frame constants and the frame event type.
`default_nettype none

module mrp_frame import mrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  device_address,
	input  wire logic [16:0] position_limit,
	output frame_evt_t       evt
);

	localparam logic [3:0] ST_ADDR = 4'd0;
	localparam logic [3:0] ST_CODE = 4'd1;
	localparam logic [3:0] ST_SIGN = 4'd2;
	localparam logic [3:0] ST_B3   = 4'd3;
	localparam logic [3:0] ST_B2   = 4'd4;
	localparam logic [3:0] ST_B1   = 4'd5;
	localparam logic [3:0] ST_B0   = 4'd6;
	localparam logic [3:0] ST_TAIL = 4'd7;
	localparam logic [3:0] ST_SKIP = 4'd8;

	logic [3:0]  stage_q, stage_d;
	logic        neg_q, neg_d;
	logic [31:0] count_q, count_d;
	logic        tail_ok;

	// Only position replies reach the tail stage, so the code is known there
	assign tail_ok = (count_q <= {15'd0, position_limit});

	// Next stage and captured fields for the current byte
	always_comb begin
		stage_d = stage_q;
		neg_d   = neg_q;
		count_d = count_q;
		evt     = '0;
		evt.neg   = neg_q;
		evt.count = count_q[16:0];
		case (stage_q)
			ST_ADDR: begin
				if (rx_byte == device_address) stage_d = ST_CODE;
			end
			ST_CODE: begin
				stage_d = (rx_byte == CODE_POSITION) ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				neg_d   = (rx_byte != 8'd0);
				stage_d = ST_B3;
			end
			ST_B3: begin
				count_d = {rx_byte, 24'd0};
				stage_d = ST_B2;
			end
			ST_B2: begin
				count_d[23:16] = rx_byte;
				stage_d = ST_B1;
			end
			ST_B1: begin
				count_d[15:8] = rx_byte;
				stage_d = ST_B0;
			end
			ST_B0: begin
				count_d[7:0] = rx_byte;
				stage_d = ST_TAIL;
			end
			ST_TAIL: begin
				if (rx_byte == TAIL_BYTE) begin
					evt.hit = accept && tail_ok;
					stage_d = ST_ADDR;
				end else if (rx_byte == device_address) begin
					// bad tail that looks like an address restarts the frame
					stage_d = ST_CODE;
				end else begin
					stage_d = ST_ADDR;
				end
			end
			ST_SKIP: begin
				if (rx_byte == TAIL_BYTE) stage_d = ST_ADDR;
			end
			default: begin
				stage_d = ST_ADDR;
			end
		endcase
	end

	// Advance parser state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_ADDR;
			neg_q   <= 1'b0;
			count_q <= 32'd0;
		end else if (accept) begin
			stage_q <= stage_d;
			neg_q   <= neg_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mrp_tenths.sv =====
// Count-to-tenths scaling, latest-angle hold and the stage-one register.
// Depends on mrp_pkg for the frame event and stage-one payload types.
`default_nettype none

module mrp_tenths import mrp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire frame_evt_t evt,
	output angle_s1_t       data_s1
);

	logic [28:0] prod;
	logic [12:0] mag_raw, mag, tenths_new;
	logic [12:0] stored_q, stored_d;
	logic        have_q, have_d;

	// Scale count by 3600/65536, saturate at a full turn, apply sign
	assign prod       = {12'd0, evt.count} * {16'd0, TENTHS_FULL};
	assign mag_raw    = prod[28:16];
	assign mag        = (mag_raw > TENTHS_FULL) ? TENTHS_FULL : mag_raw;
	assign tenths_new = evt.neg ? (13'd0 - mag) : mag;

	assign stored_d = evt.hit ? tenths_new : stored_q;
	assign have_d   = have_q | evt.hit;

	// Hold the latest accepted angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= 13'd0;
			have_q   <= 1'b0;
		end else if (accept) begin
			stored_q <= stored_d;
			have_q   <= have_d;
		end
	end

	// Load stage-one payload with each accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.updated <= evt.hit;
			data_s1.have    <= have_d;
			data_s1.tenths  <= stored_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mrp_degrees.sv =====
// Degree rounding and the result register driving the output payload.
// Depends on mrp_pkg for the stage-one payload type and rounding constants.
`default_nettype none

module mrp_degrees import mrp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire angle_s1_t     data_s1,
	output logic               position_valid,
	output logic               position_updated,
	output logic signed [12:0] angle_tenths,
	output logic signed [9:0]  angle_degrees
);

	logic        neg;
	logic [11:0] mag;
	logic [11:0] biased;
	logic [24:0] prod;
	logic [8:0]  quot;
	logic [9:0]  deg;

	// Round |t|/10 half away from zero, then restore the sign
	assign neg    = data_s1.tenths[12];
	assign mag    = neg ? 12'(13'd0 - data_s1.tenths) : data_s1.tenths[11:0];
	assign biased = mag + ROUND_HALF;
	assign prod   = {13'd0, biased} * {12'd0, RECIP_TEN};
	assign quot   = prod[24:16];
	assign deg    = neg ? (10'd0 - {1'b0, quot}) : {1'b0, quot};

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			position_valid   <= data_s1.have;
			position_updated <= data_s1.updated;
			angle_tenths     <= data_s1.tenths;
			angle_degrees    <= deg;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/motor_position_reply_parser.sv =====
// Top level: configuration registers, handshake control, parser and result stages.
// Depends on mrp_pkg, mrp_frame, mrp_tenths and mrp_degrees.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    rx_byte
//   result    out        out_valid / out_stall  position_valid, position_updated,
//                                               angle_tenths, angle_degrees
//   config    in         cfg_we                 cfg_index, cfg_data
//
// One result beat per input byte; a byte can be taken every cycle while the
// result side does not stall. Parser and scaling load stage one, degree rounding
// loads the result register. Reset clears parser state, the held angle and the
// stage valid flags. Stall on the result side backs up through stage one to
// in_stall; bubbles are squeezed out while a result waits.
`default_nettype none

module motor_position_reply_parser import mrp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       position_valid,
	output logic                       position_updated,
	output logic signed [12:0]         angle_tenths,
	output logic signed [9:0]          angle_degrees,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]  device_address_q;
	logic [16:0] position_limit_q;
	logic        valid_s1;
	logic        out_valid_q;
	logic        ready_out, ready_s1, accept;
	frame_evt_t  evt;
	angle_s1_t   data_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEV_ADDR_RST;
			position_limit_q <= POS_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: device_address_q <= cfg_data[7:0];
				REG_POSITION_LIMIT: position_limit_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Per-stage ready chain
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s1  = !valid_s1 || ready_out;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;
	assign out_valid = out_valid_q;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= accept;
			if (ready_out) out_valid_q <= valid_s1;
		end
	end

	mrp_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.rx_byte        (rx_byte),
		.device_address (device_address_q),
		.position_limit (position_limit_q),
		.evt            (evt)
	);

	mrp_tenths u_tenths (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.evt     (evt),
		.data_s1 (data_s1)
	);

	mrp_degrees u_degrees (
		.clk              (clk),
		.load             (valid_s1 && ready_out),
		.data_s1          (data_s1),
		.position_valid   (position_valid),
		.position_updated (position_updated),
		.angle_tenths     (angle_tenths),
		.angle_degrees    (angle_degrees)
	);

endmodule

`default_nettype wire

// ===== rtl/mrp_checker.sv =====
// Port-level checker for the motor position reply parser, bound to the top.
// Depends only on the top-level ports.
`default_nettype none

module mrp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               position_valid,
	input wire logic               position_updated,
	input wire logic signed [12:0] angle_tenths,
	input wire logic signed [9:0]  angle_degrees
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// An update implies a held position
	a_upd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position_updated |-> position_valid)
		else $error("update without position_valid");

	// No position yet means a zero angle
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !position_valid |-> angle_tenths == 13'sd0 && angle_degrees == 10'sd0)
		else $error("angle nonzero before first position");

	// Angle stays within one turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_tenths <= 13'sd3600 && angle_tenths >= -13'sd3600)
		else $error("angle_tenths out of range");

	// Non-negative tenths give non-negative degrees
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && angle_tenths >= 13'sd0 |-> angle_degrees >= 10'sd0)
		else $error("angle_degrees sign mismatch");

endmodule

bind motor_position_reply_parser mrp_checker u_mrp_checker (.*);

`default_nettype wire

// ===== tb/sv/motor_position_reply_parser_tb.sv =====
// Self-checking testbench for motor_position_reply_parser: directed frames, then random traffic.
// Depends on mrp_pkg and the parser RTL; a local model predicts the result beats that directed rows do not fix.
`default_nettype none

module motor_position_reply_parser_tb import mrp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 90;
	localparam int DIR_ROWS       = 27;

	typedef enum logic [3:0] {
		STG_ADDR, STG_CODE, STG_SIGN, STG_B3, STG_B2, STG_B1, STG_B0, STG_TAIL, STG_SKIP
	} stage_e;

	typedef struct packed {
		logic               pos_valid;
		logic               pos_updated;
		logic signed [12:0] tenths;
		logic signed [9:0]  degrees;
	} angle_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fixed;
		angle_res_t res;
	} dir_row_t;

	localparam angle_res_t RES_NONE      = '0;
	localparam angle_res_t RES_FULL_POS  = {1'b1, 1'b1, 13'sd3600, 10'sd360};
	localparam angle_res_t RES_KEPT_FULL = {1'b1, 1'b0, 13'sd3600, 10'sd360};
	localparam angle_res_t RES_NEG_ZERO  = {1'b1, 1'b1, 13'sd0, 10'sd0};
	localparam angle_res_t RES_KEPT_ZERO = {1'b1, 1'b0, 13'sd0, 10'sd0};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  position_valid;
	logic                  position_updated;
	logic signed [12:0]    angle_tenths;
	logic signed [9:0]     angle_degrees;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_DEVICE_ADDRESS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Local copy of the parser state and its configuration
	logic [7:0]         dev_addr;
	logic [16:0]        pos_limit;
	stage_e             parse_stage;
	logic [7:0]         seen_code;
	logic               seen_neg;
	logic [31:0]        count_acc;
	logic signed [12:0] held_tenths;
	logic               have_angle;

	angle_res_t expected_angles[$];
	dir_row_t   dir_rows [DIR_ROWS];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int mismatch_cnt = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;

	motor_position_reply_parser u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.position_valid   (position_valid),
		.position_updated (position_updated),
		.angle_tenths     (angle_tenths),
		.angle_degrees    (angle_degrees),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the local parser by one byte and return the angle beat it produces
	function automatic angle_res_t predict_angle(input logic [7:0] b);
		angle_res_t  res;
		logic        updated;
		logic [63:0] mag;
		int          t;
		int          d;
		updated = 1'b0;
		case (parse_stage)
			STG_ADDR: begin
				if (b == dev_addr)
					parse_stage = STG_CODE;
			end
			STG_CODE: begin
				seen_code   = b;
				parse_stage = (b == CODE_POSITION) ? STG_SIGN : STG_SKIP;
			end
			STG_SIGN: begin
				seen_neg    = (b != 8'h00);
				parse_stage = STG_B3;
			end
			STG_B3: begin
				count_acc   = {b, 24'h000000};
				parse_stage = STG_B2;
			end
			STG_B2: begin
				count_acc[23:16] = b;
				parse_stage      = STG_B1;
			end
			STG_B1: begin
				count_acc[15:8] = b;
				parse_stage     = STG_B0;
			end
			STG_B0: begin
				count_acc[7:0] = b;
				parse_stage    = STG_TAIL;
			end
			STG_TAIL: begin
				if (b == TAIL_BYTE) begin
					if (seen_code == CODE_POSITION && count_acc <= 32'(pos_limit)) begin
						// Scale to tenths, saturate at a full turn
						mag = (64'(count_acc) * 64'd3600) >> 16;
						if (mag > 64'd3600)
							mag = 64'd3600;
						held_tenths = seen_neg ? -13'(mag) : 13'(mag);
						have_angle  = 1'b1;
						updated     = 1'b1;
					end
					parse_stage = STG_ADDR;
				end else if (b == dev_addr) begin
					parse_stage = STG_CODE;
				end else begin
					parse_stage = STG_ADDR;
				end
			end
			STG_SKIP: begin
				if (b == TAIL_BYTE)
					parse_stage = STG_ADDR;
			end
			default: parse_stage = STG_ADDR;
		endcase
		t = have_angle ? int'(held_tenths) : 0;
		d = (t >= 0) ? (t + 5) / 10 : -((-t + 5) / 10);
		res.pos_valid   = have_angle;
		res.pos_updated = updated;
		res.tenths      = t[12:0];
		res.degrees     = d[9:0];
		return res;
	endfunction

	function automatic void log_mismatch(input string what, input angle_res_t e,
					     input angle_res_t g);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display({"[%0t] %s: exp valid=%0b upd=%0b tenths=%0d deg=%0d, ",
				  "got valid=%0b upd=%0b tenths=%0d deg=%0d"},
				 $realtime, what, e.pos_valid, e.pos_updated, e.tenths, e.degrees,
				 g.pos_valid, g.pos_updated, g.tenths, g.degrees);
	endfunction

	// Offer one byte, hold it until taken, then log its expected beat
	task automatic send_byte(input logic [7:0] b, input logic fixed, input angle_res_t fixed_res);
		angle_res_t pred;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		pred = predict_angle(b);
		expected_angles.push_back(fixed ? fixed_res : pred);
		bytes_sent++;
	endtask

	// Stop offering and wait until every expected beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic write_config(input logic [7:0] addr, input logic [16:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data  <= CFG_DATA_W'(addr);
		@(posedge clk);
		cfg_index <= REG_POSITION_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dev_addr  = addr;
		pos_limit = limit;
	endtask

	// Mostly well-formed replies with random content, plus noise and cut-off frames
	task automatic send_reply_traffic(input int n_bytes);
		int          start;
		int          kind;
		int          k;
		logic [31:0] cnt;
		logic [7:0]  v;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				if (parse_stage != STG_CODE)
					send_byte(dev_addr, 1'b0, RES_NONE);
				send_byte(CODE_POSITION, 1'b0, RES_NONE);
				v = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'h00;
				send_byte(v, 1'b0, RES_NONE);
				case ($urandom_range(5))
					0: cnt = $urandom_range(pos_limit);
					1: cnt = 32'(pos_limit);
					2: cnt = 32'(pos_limit) + 32'd1;
					3: cnt = $urandom();
					4: cnt = 32'd0;
					default: cnt = $urandom_range(255);
				endcase
				send_byte(cnt[31:24], 1'b0, RES_NONE);
				send_byte(cnt[23:16], 1'b0, RES_NONE);
				send_byte(cnt[15:8], 1'b0, RES_NONE);
				send_byte(cnt[7:0], 1'b0, RES_NONE);
				k = $urandom_range(9);
				if (k < 8)
					v = TAIL_BYTE;
				else if (k == 8)
					v = dev_addr;
				else
					v = 8'($urandom_range(255));
				send_byte(v, 1'b0, RES_NONE);
			end else if (kind < 75) begin
				// Reply with another code: skipped up to the tail
				if (parse_stage != STG_CODE)
					send_byte(dev_addr, 1'b0, RES_NONE);
				v = 8'($urandom_range(255));
				if (v == CODE_POSITION)
					v = CODE_POSITION + 8'd1;
				send_byte(v, 1'b0, RES_NONE);
				k = $urandom_range(4);
				repeat (k) begin
					v = 8'($urandom_range(255));
					if (v == TAIL_BYTE)
						v = 8'h00;
					send_byte(v, 1'b0, RES_NONE);
				end
				send_byte(TAIL_BYTE, 1'b0, RES_NONE);
			end else if (kind < 90) begin
				send_byte(8'($urandom_range(255)), 1'b0, RES_NONE);
			end else begin
				// Frame cut short by random bytes
				send_byte(dev_addr, 1'b0, RES_NONE);
				send_byte(CODE_POSITION, 1'b0, RES_NONE);
				k = $urandom_range(5);
				repeat (k)
					send_byte(8'($urandom_range(255)), 1'b0, RES_NONE);
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] addr, input logic [16:0] limit, input int idle,
				 input int stall, input int n_bytes, input logic with_hold);
		write_config(addr, limit);
		idle_pct  = idle;
		stall_pct = stall;
		if (with_hold)
			hold_req <= HOLD_CYCLES;
		send_reply_traffic(n_bytes);
		drain();
	endtask

	// Result side: check each beat taken, then pick the stall for the next cycle
	always @(posedge clk) begin
		angle_res_t got;
		angle_res_t exp_res;
		if (out_valid && !out_stall) begin
			got = {position_valid, position_updated, angle_tenths, angle_degrees};
			if (expected_angles.size() == 0) begin
				log_mismatch("beat with nothing expected", RES_NONE, got);
			end else begin
				exp_res = expected_angles.pop_front();
				if (got.pos_valid !== exp_res.pos_valid || got.pos_updated !== exp_res.pos_updated ||
				    got.tenths !== exp_res.tenths || got.degrees !== exp_res.degrees)
					log_mismatch("angle beat mismatch", exp_res, got);
			end
		end
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req <= 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		dir_rows = '{
			'{8'hFF, 1'b1, RES_NONE},      // noise while waiting for an address
			'{8'h01, 1'b1, RES_NONE},
			'{8'h36, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h01, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h6B, 1'b1, RES_FULL_POS},  // count at the limit, full turn
			'{8'h01, 1'b0, RES_NONE},
			'{8'h36, 1'b0, RES_NONE},
			'{8'hFF, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'hFF, 1'b0, RES_NONE},
			'{8'hFF, 1'b0, RES_NONE},
			'{8'h01, 1'b1, RES_KEPT_FULL}, // bad tail equal to address restarts
			'{8'h36, 1'b0, RES_NONE},
			'{8'h80, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h00, 1'b0, RES_NONE},
			'{8'h6B, 1'b1, RES_NEG_ZERO},  // negative zero
			'{8'h01, 1'b0, RES_NONE},
			'{8'h10, 1'b0, RES_NONE},      // other code, skipped
			'{8'h6B, 1'b1, RES_KEPT_ZERO}
		};

		// Reset values of the local parser
		dev_addr    = DEV_ADDR_RST;
		pos_limit   = POS_LIMIT_RST;
		parse_stage = STG_ADDR;
		seen_code   = 8'h00;
		seen_neg    = 1'b0;
		count_acc   = 32'd0;
		held_tenths = 13'sd0;
		have_angle  = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset configuration
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].res);
		drain();

		run_phase(8'h5A, 17'h10000, 0, 0, 90, 1'b0);
		run_phase(8'h00, 17'h00000, 47, 0, 70, 1'b0);
		run_phase(8'hFF, 17'h1FFFF, 0, 47, 80, 1'b1);
		run_phase(8'h6B, 17'd40000, 10, 10, 70, 1'b0);
		run_phase(8'h36, 17'h0FFFF, 0, 0, 70, 1'b1);

		if (mismatch_cnt == 0 && expected_angles.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
